[sv/iet_pkg.sv]
// ----------------------------------------------------------------------------
// iet_pkg
// Types, token kind codes and character classes shared by the tokenizer.
// ----------------------------------------------------------------------------
package iet_pkg;

   localparam logic [1:0] KIND_NUMBER   = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_NAME     = 2'd2;

   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PCT    = 8'h25;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // most results one character can cause
   localparam int unsigned SLOTS = 3;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_expression;
   } req_type;

   typedef struct packed {
      logic [7:0] token_char;
      logic [1:0] token_kind;
      logic       token_end;
      logic       expression_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] token_char;
      logic [1:0] token_kind;
      logic       token_end;
   } result_type;

   // all results caused by one character, in emit order
   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [1:0]             count;
      logic                   expr_last;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return is_digit(c) || (c == CHAR_DOT);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_SLASH) ||
             (c == CHAR_STAR) || (c == CHAR_PCT) || (c == CHAR_LPAREN) ||
             (c == CHAR_RPAREN) || (c == CHAR_CARET);
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] c);
      logic [1:0] k;
      k = KIND_NAME;
      if (is_num(c)) k = KIND_NUMBER;
      else if (is_op(c)) k = KIND_OPERATOR;
      return k;
   endfunction

endpackage

[sv/iet_front.sv]
// ----------------------------------------------------------------------------
// iet_front
// Holds the pending character and turns each incoming character into a bundle
// of up to three token results.
// ----------------------------------------------------------------------------
module iet_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  iet_pkg::req_type    req_data,
   input  logic                full,
   output logic                push,
   output iet_pkg::bundle_type push_data
);
   import iet_pkg::*;

   logic [7:0] prev_char_ff, prev_char_in;
   logic       prev_valid_ff, prev_valid_in;
   logic       accept;
   logic [7:0] ch;
   logic       last;
   logic       c0_v, c1_v, c2_v, c3_v, star;
   result_type c0, c1, c2, c3;
   bundle_type bundle;
   logic [1:0] n;

   assign ch        = req_data.ch;
   assign last      = req_data.end_of_expression;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_comb begin
      // pending character, now that its follower is known
      c0_v = prev_valid_ff && (is_num(prev_char_ff) || is_op(prev_char_ff) ||
                               is_alpha(prev_char_ff));
      c0.token_char = prev_char_ff;
      c0.token_kind = kind_of(prev_char_ff);
      if (is_num(prev_char_ff)) c0.token_end = !is_num(ch);
      else if (is_op(prev_char_ff)) c0.token_end = 1'b1;
      else c0.token_end = !is_alpha(ch);

      // implicit multiply
      star = ((is_digit(prev_char_ff) || (prev_char_ff == CHAR_RPAREN)) &&
              ((ch == CHAR_LPAREN) || is_alpha(ch))) ||
             ((prev_char_ff == CHAR_RPAREN) && is_digit(ch));
      c1_v = prev_valid_ff && star;
      c1.token_char = CHAR_STAR;
      c1.token_kind = KIND_OPERATOR;
      c1.token_end  = 1'b1;

      // leading zero for a number that opens with a dot
      c2_v = (ch == CHAR_DOT) && !(prev_valid_ff && is_num(prev_char_ff));
      c2.token_char = CHAR_ZERO;
      c2.token_kind = KIND_NUMBER;
      c2.token_end  = 1'b0;

      // final character flushes with no follower
      c3_v = last && (is_num(ch) || is_op(ch) || is_alpha(ch));
      c3.token_char = ch;
      c3.token_kind = kind_of(ch);
      c3.token_end  = 1'b1;

      bundle = '0;
      n = 2'd0;
      if (c0_v) begin
         bundle.slot[n] = c0;
         n = n + 2'd1;
      end
      if (c1_v) begin
         bundle.slot[n] = c1;
         n = n + 2'd1;
      end
      if (c2_v) begin
         bundle.slot[n] = c2;
         n = n + 2'd1;
      end
      if (c3_v) begin
         bundle.slot[n] = c3;
         n = n + 2'd1;
      end
      bundle.count     = n;
      bundle.expr_last = last;
   end

   assign push      = accept && (bundle.count != 2'd0);
   assign push_data = bundle;

   always_comb begin
      prev_char_in  = prev_char_ff;
      prev_valid_in = prev_valid_ff;
      if (accept) begin
         prev_char_in  = last ? 8'd0 : ch;
         prev_valid_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff  <= 8'd0;
         prev_valid_ff <= 1'b0;
      end else begin
         prev_char_ff  <= prev_char_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

endmodule

[sv/iet_queue.sv]
// ----------------------------------------------------------------------------
// iet_queue
// Small first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module iet_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  iet_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output iet_pkg::bundle_type head_data
);
   import iet_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   bundle_type        entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[sv/iet_back.sv]
// ----------------------------------------------------------------------------
// iet_back
// Walks the bundle at the head of the queue and hands out one token result
// per transaction.
// ----------------------------------------------------------------------------
module iet_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  iet_pkg::bundle_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output iet_pkg::rsp_type    rsp_data
);
   import iet_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       run_last;
   logic       accept;
   result_type cur;

   assign cur       = head_data.slot[idx_ff];
   assign run_last  = (idx_ff == (head_data.count - 2'd1));
   assign rsp_valid = head_valid;
   assign accept    = head_valid && !rsp_stall;
   assign pop       = accept && run_last;

   always_comb begin
      rsp_data.token_char     = cur.token_char;
      rsp_data.token_kind     = cur.token_kind;
      rsp_data.token_end      = cur.token_end;
      rsp_data.expression_end = run_last && head_data.expr_last;
      rsp_data.run_last       = run_last;
   end

   always_comb begin
      idx_in = idx_ff;
      if (accept) idx_in = run_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[sv/infix_expression_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// infix_expression_tokenizer_unit
// Streaming tokenizer for ASCII infix expressions.
// ----------------------------------------------------------------------------
// A character is accepted every cycle while the result queue has room; each
// character yields zero to three token results (the held-back previous
// character, an implicit '*', a leading '0', and on the final character the
// character itself), and the result port delivers one result per cycle while
// rsp_stall is low. The front stage classifies a character in the cycle it is
// accepted and pushes its results as one entry into a QUEUE_DEPTH-entry queue,
// so results appear on the next cycle at the earliest; sustained input rate is
// one character per cycle as long as characters average no more than one result
// each, and otherwise it is set by the one-result-per-cycle output port.
module infix_expression_tokenizer_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iet_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iet_pkg::rsp_type rsp_data
);
   import iet_pkg::*;

   logic       push, pop, full, head_valid;
   bundle_type push_data, head_data;

   iet_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   iet_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   iet_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
